// ----- rtl/assert_macros.svh -----
// assertion helpers used by the scheduler top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define ERT_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define ERT_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/ert_pkg.sv -----
package ert_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int TIME_BITS_DEF = 12;

    localparam int SLOT_W  = 3;
    localparam int FIELD_W = 12;
    localparam int JOB_W   = 16;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_DEFINE = 1'b1;

    localparam logic POLICY_EDF = 1'b0;
    localparam logic POLICY_RMS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } ert_state_t;

    // control shared by every cell in the chain
    typedef struct packed {
        logic policy;
        logic apply;
    } cell_ctrl_t;

endpackage

// ----- rtl/ert_cell.sv -----
module ert_cell
    import ert_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int SLOT_ID   = 0,
    localparam int IDX_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cell_ctrl_t           ctrl,
    input  logic                 def_sel,
    input  logic [TIME_BITS-1:0] def_exec,
    input  logic [TIME_BITS-1:0] def_period,
    input  logic                 scan_sel,
    input  logic                 in_valid,
    input  logic [TIME_BITS-1:0] in_key,
    input  logic [IDX_W-1:0]     in_idx,
    input  logic [JOB_W-1:0]     in_job,
    input  logic                 in_done,
    output logic                 out_valid,
    output logic [TIME_BITS-1:0] out_key,
    output logic [IDX_W-1:0]     out_idx,
    output logic [JOB_W-1:0]     out_job,
    output logic                 out_done,
    input  logic                 win_valid,
    input  logic [IDX_W-1:0]     win_idx
);

    localparam logic [TIME_BITS-1:0] ONE_T = TIME_BITS'(1);

    logic                 defined_reg, defined_next;
    logic                 ready_reg, ready_next;
    logic [TIME_BITS-1:0] exec_reg, exec_next;
    logic [TIME_BITS-1:0] prem_reg, prem_next;
    logic [TIME_BITS-1:0] erel_reg, erel_next;
    logic [TIME_BITS-1:0] prel_reg, prel_next;
    logic [JOB_W-1:0]     job_reg, job_next;

    logic                 valid_reg, valid_next;
    logic [TIME_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [JOB_W-1:0]     jout_reg, jout_next;
    logic                 done_reg, done_next;

    logic [TIME_BITS-1:0] my_key;
    logic                 take_mine;
    logic                 is_winner;

    assign my_key    = (ctrl.policy == POLICY_RMS) ? prel_reg : prem_reg;
    assign take_mine = defined_reg && ready_reg && (!in_valid || (my_key < in_key));
    assign is_winner = win_valid && (win_idx == IDX_W'(SLOT_ID));

    // running minimum handed on to the next cell
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        jout_next  = jout_reg;
        done_next  = done_reg;
        if (scan_sel) begin
            if (take_mine) begin
                valid_next = 1'b1;
                key_next   = my_key;
                idx_next   = IDX_W'(SLOT_ID);
                jout_next  = job_reg;
                done_next  = (exec_reg <= ONE_T);
            end else begin
                valid_next = in_valid;
                key_next   = in_key;
                idx_next   = in_idx;
                jout_next  = in_job;
                done_next  = in_done;
            end
        end
    end

    // slot state: define, run one unit, count the period down
    always_comb begin
        defined_next = defined_reg;
        ready_next   = ready_reg;
        exec_next    = exec_reg;
        prem_next    = prem_reg;
        erel_next    = erel_reg;
        prel_next    = prel_reg;
        job_next     = job_reg;
        if (def_sel) begin
            defined_next = (def_exec != '0);
            ready_next   = (def_exec != '0);
            exec_next    = def_exec;
            erel_next    = def_exec;
            prem_next    = def_period;
            prel_next    = def_period;
            job_next     = JOB_W'(1);
        end else if (ctrl.apply) begin
            if (is_winner) begin
                if (exec_reg != '0) begin
                    exec_next = exec_reg - ONE_T;
                end
                if (exec_reg <= ONE_T) begin
                    ready_next = 1'b0;
                    job_next   = job_reg + JOB_W'(1);
                end
            end
            if (defined_reg) begin
                if (prem_reg <= ONE_T) begin
                    prem_next  = prel_reg;
                    exec_next  = erel_reg;
                    ready_next = 1'b1;
                end else begin
                    prem_next = prem_reg - ONE_T;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            defined_reg <= 1'b0;
            ready_reg   <= 1'b0;
            exec_reg    <= '0;
            prem_reg    <= '0;
            erel_reg    <= '0;
            prel_reg    <= '0;
            job_reg     <= '1;
            valid_reg   <= 1'b0;
        end else begin
            defined_reg <= defined_next;
            ready_reg   <= ready_next;
            exec_reg    <= exec_next;
            prem_reg    <= prem_next;
            erel_reg    <= erel_next;
            prel_reg    <= prel_next;
            job_reg     <= job_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        idx_reg  <= idx_next;
        jout_reg <= jout_next;
        done_reg <= done_next;
    end

    assign out_valid = valid_reg;
    assign out_key   = key_reg;
    assign out_idx   = idx_reg;
    assign out_job   = jout_reg;
    assign out_done  = done_reg;

endmodule

// ----- rtl/edf_rms_tick_scheduler.sv -----
// Periodic task scheduler, one time tick per tick beat. A define beat
// (s_tuser = 1) loads a task slot with its execution time and period, makes
// its first job ready and returns no beat; it is taken in the idle state. A
// tick beat (s_tuser = 0) picks the ready task with the smallest remaining
// period (policy 0, earliest deadline first) or the smallest period (policy
// 1, rate monotonic), lowest slot on a tie, runs it for one unit, counts all
// periods down and returns one result beat. Each slot lives in one cell of a
// chain; the running minimum moves one cell per cycle. A tick passes from
// the accept in the idle state through the scan state, in which each cell
// takes its turn in slot order, and on to the update state. The update
// cycle waits while an earlier result is still held on the output. The
// policy register may be written at any time the block is idle and takes
// effect at the next tick.
`include "assert_macros.svh"

module edf_rms_tick_scheduler
    import ert_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // policy register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,       // policy_mode
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // task_slot, exec_time, period_len, zero pad
    input  logic        s_tuser,        // operation
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // running_slot, job_finished, job_index,
                                        // context_switch, zero pad
    output logic        m_tuser         // idle_tick
);

    localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int STEP_W = IDX_W;

    // input field unpack
    logic [SLOT_W-1:0]  in_slot;
    logic [FIELD_W-1:0] in_exec;
    logic [FIELD_W-1:0] in_period;
    assign in_slot   = s_tdata[2:0];
    assign in_exec   = s_tdata[14:3];
    assign in_period = s_tdata[26:15];

    // fields cut (or zero extended) to the time width
    logic [31:0]          exec_wide, period_wide;
    logic [TIME_BITS-1:0] exec_cut, period_cut, period_fixed;
    assign exec_wide    = {{(32-FIELD_W){1'b0}}, in_exec};
    assign period_wide  = {{(32-FIELD_W){1'b0}}, in_period};
    assign exec_cut     = exec_wide[TIME_BITS-1:0];
    assign period_cut   = period_wide[TIME_BITS-1:0];
    // a zero period is kept as one tick
    assign period_fixed = (period_cut == '0) ? TIME_BITS'(1) : period_cut;

    logic s_acc, define_acc, tick_acc;
    assign s_acc      = s_tvalid && s_tready;
    assign define_acc = s_acc && (s_tuser == OP_DEFINE);
    assign tick_acc   = s_acc && (s_tuser == OP_TICK);

    // policy register
    logic policy_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POLICY_EDF;
        end else if (cfg_valid && cfg_ready) begin
            policy_reg <= cfg_data;
        end
    end

    // sequencer
    ert_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              fire;
    logic              m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        fire       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (tick_acc) begin
                    step_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // last cell takes its turn now: the result is at the chain end in the update state
                if (step_reg == STEP_W'(MAX_TASKS - 1)) begin
                    state_next = ST_APPLY;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_APPLY: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_tready) begin
                    fire       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // chain of slot cells
    cell_ctrl_t ctrl;
    assign ctrl.policy = policy_reg;
    assign ctrl.apply  = fire;

    logic                 c_valid [MAX_TASKS];
    logic [TIME_BITS-1:0] c_key   [MAX_TASKS];
    logic [IDX_W-1:0]     c_idx   [MAX_TASKS];
    logic [JOB_W-1:0]     c_job   [MAX_TASKS];
    logic                 c_done  [MAX_TASKS];

    logic                 win_valid;
    logic [IDX_W-1:0]     win_idx;
    logic [JOB_W-1:0]     win_job;
    logic                 win_done;
    assign win_valid = c_valid[MAX_TASKS-1];
    assign win_idx   = c_idx[MAX_TASKS-1];
    assign win_job   = c_job[MAX_TASKS-1];
    assign win_done  = c_done[MAX_TASKS-1];

    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
        logic                 p_valid;
        logic [TIME_BITS-1:0] p_key;
        logic [IDX_W-1:0]     p_idx;
        logic [JOB_W-1:0]     p_job;
        logic                 p_done;
        logic                 def_sel;
        logic                 scan_sel;

        if (k == 0) begin : g_head
            // the chain starts with no candidate
            assign p_valid = 1'b0;
            assign p_key   = '0;
            assign p_idx   = '0;
            assign p_job   = '0;
            assign p_done  = 1'b0;
        end else begin : g_link
            assign p_valid = c_valid[k-1];
            assign p_key   = c_key[k-1];
            assign p_idx   = c_idx[k-1];
            assign p_job   = c_job[k-1];
            assign p_done  = c_done[k-1];
        end

        // slots at or above MAX_TASKS never match, so those defines drop
        assign def_sel  = define_acc && (int'(in_slot) == k);
        assign scan_sel = (state_reg == ST_SCAN) && (step_reg == STEP_W'(k));

        ert_cell #(
            .MAX_TASKS (MAX_TASKS),
            .TIME_BITS (TIME_BITS),
            .SLOT_ID   (k)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .def_sel    (def_sel),
            .def_exec   (exec_cut),
            .def_period (period_fixed),
            .scan_sel   (scan_sel),
            .in_valid   (p_valid),
            .in_key     (p_key),
            .in_idx     (p_idx),
            .in_job     (p_job),
            .in_done    (p_done),
            .out_valid  (c_valid[k]),
            .out_key    (c_key[k]),
            .out_idx    (c_idx[k]),
            .out_job    (c_job[k]),
            .out_done   (c_done[k]),
            .win_valid  (win_valid),
            .win_idx    (win_idx)
        );
    end

    // previous choice, idle after reset
    logic             prev_idle_reg;
    logic [IDX_W-1:0] prev_idx_reg;
    logic             switch_now;
    assign switch_now = win_valid ? (prev_idle_reg || (prev_idx_reg != win_idx))
                                  : !prev_idle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_idle_reg <= 1'b1;
        end else if (fire) begin
            prev_idle_reg <= !win_valid;
        end
    end

    // result register
    logic [31:0]       win_idx_wide;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_idle_reg;
    logic              out_fin_reg;
    logic [JOB_W-1:0]  out_job_reg;
    logic              out_sw_reg;
    assign win_idx_wide = 32'(win_idx);

    always_ff @(posedge aclk) begin
        if (fire) begin
            prev_idx_reg <= win_idx;
            out_slot_reg <= win_valid ? win_idx_wide[SLOT_W-1:0] : '0;
            out_idle_reg <= !win_valid;
            out_fin_reg  <= win_valid && win_done;
            out_job_reg  <= win_valid ? win_job : '0;
            out_sw_reg   <= switch_now;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_sw_reg, out_job_reg, out_fin_reg, out_slot_reg};
    assign m_tuser  = out_idle_reg;

    // checks
    `ERT_ASSERT_NEXT(a_tick_blocks_input, aclk, aresetn, tick_acc, !s_tready,
        "tick accepted but input still ready next cycle")
    `ERT_ASSERT_NEXT(a_define_no_result, aclk, aresetn, define_acc && !m_valid_reg,
        !m_valid_reg, "define beat produced a result")
    `ERT_ASSERT_NOW(a_idle_result_clean, aclk, aresetn, m_valid_reg && out_idle_reg,
        !out_fin_reg && (out_job_reg == '0) && (out_slot_reg == '0),
        "idle result carries task data")
    `ERT_ASSERT_NOW(a_fire_only_in_update, aclk, aresetn, fire,
        state_reg == ST_APPLY, "result loaded outside the update cycle")

endmodule

// ----- dv/edf_rms_tick_scheduler_test.sv -----
`timescale 1ns / 1ps

module edf_rms_tick_scheduler_test
    import ert_pkg::*;
();

    localparam int NUM_SLOTS = MAX_TASKS_DEF;
    localparam logic [3:0] IDLE_CODE = 4'd8;
    // wait well past the length of one tick before a policy write
    localparam int SETTLE_CYCLES = 3 * (NUM_SLOTS + 2);
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX = 10;

    // one pending input beat
    typedef struct {
        logic                op;
        logic [SLOT_W-1:0]   slot;
        logic [FIELD_W-1:0]  exec_t;
        logic [FIELD_W-1:0]  period;
        bit                  drain;     // hold off until every tick result is back
    } sched_item_t;

    // one tick result
    typedef struct {
        logic [SLOT_W-1:0] running_slot;
        logic              idle_tick;
        logic              job_finished;
        logic [JOB_W-1:0]  job_index;
        logic              context_switch;
    } tick_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = POLICY_EDF;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // task_slot, exec_time, period_len, zero pad
    logic        s_tuser = OP_TICK; // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // running_slot, job_finished, job_index,
                                    // context_switch, zero pad
    logic        m_tuser;           // idle_tick

    sched_item_t  pending [$];
    tick_result_t tick_expect [$];
    sched_item_t  on_bus;

    int unsigned send_idle_pct = 29;
    int unsigned recv_stall_pct = 63;
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          drain_next = 1'b0;

    // scheduler state as the testbench sees it
    bit                 slot_on [NUM_SLOTS] = '{default: 1'b0};
    bit                 ready [NUM_SLOTS] = '{default: 1'b0};
    logic [FIELD_W-1:0] exec_left [NUM_SLOTS] = '{default: '0};
    logic [FIELD_W-1:0] period_left [NUM_SLOTS] = '{default: '0};
    logic [FIELD_W-1:0] exec_rel [NUM_SLOTS] = '{default: '0};
    logic [FIELD_W-1:0] period_rel [NUM_SLOTS] = '{default: '0};
    logic [JOB_W-1:0]   job_num [NUM_SLOTS] = '{default: '1};
    logic [3:0]         last_choice = IDLE_CODE;
    logic               policy = POLICY_EDF;

    edf_rms_tick_scheduler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // pick, run one unit, then count every period down
    function automatic tick_result_t run_tick();
        tick_result_t       res;
        int                 best;
        logic [FIELD_W-1:0] best_key;
        logic [FIELD_W-1:0] key;
        logic [3:0]         code;
        best = -1;
        best_key = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (slot_on[s] && ready[s]) begin
                key = (policy == POLICY_RMS) ? period_rel[s] : period_left[s];
                // strict compare keeps the lowest slot on a tie
                if (best < 0 || key < best_key) begin
                    best = s;
                    best_key = key;
                end
            end
        end
        code = (best < 0) ? IDLE_CODE : 4'(best);
        res.context_switch = (code != last_choice);
        last_choice = code;
        if (best < 0) begin
            res.running_slot = '0;
            res.idle_tick = 1'b1;
            res.job_finished = 1'b0;
            res.job_index = '0;
        end else begin
            res.running_slot = SLOT_W'(best);
            res.idle_tick = 1'b0;
            res.job_index = job_num[best];
            if (exec_left[best] != 0)
                exec_left[best] = exec_left[best] - 1'b1;
            res.job_finished = (exec_left[best] == 0);
            if (res.job_finished) begin
                ready[best] = 1'b0;
                job_num[best] = job_num[best] + 1'b1;
            end
        end
        // period rollover reloads and readies the job, overrun restarts silently
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (slot_on[s]) begin
                if (period_left[s] <= 1) begin
                    period_left[s] = period_rel[s];
                    exec_left[s] = exec_rel[s];
                    ready[s] = 1'b1;
                end else begin
                    period_left[s] = period_left[s] - 1'b1;
                end
            end
        end
        return res;
    endfunction

    // update the expected state for one accepted beat
    function automatic void apply_item(input sched_item_t it);
        logic [FIELD_W-1:0] per;
        if (it.op == OP_DEFINE) begin
            per = (it.period == 0) ? FIELD_W'(1) : it.period;
            exec_rel[it.slot] = it.exec_t;
            period_rel[it.slot] = per;
            exec_left[it.slot] = it.exec_t;
            period_left[it.slot] = per;
            // zero execution time takes the slot out of the schedule
            slot_on[it.slot] = (it.exec_t != 0);
            ready[it.slot] = (it.exec_t != 0);
            job_num[it.slot] = JOB_W'(1);
        end else begin
            tick_expect.push_back(run_tick());
        end
    endfunction

    task automatic log_fail(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endtask

    // input driver: one beat at a time from the pending queue
    always @(posedge aclk) begin : feed_proc
        bit take;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                apply_item(on_bus);
            if (!s_tvalid || s_tready) begin
                take = pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
                // some beats wait for the result stream to drain completely
                if (take && pending[0].drain && tick_expect.size() != 0)
                    take = 1'b0;
                if (take) begin
                    on_bus = pending.pop_front();
                    s_tdata <= {5'b0, on_bus.period, on_bus.exec_t, on_bus.slot};
                    s_tuser <= on_bus.op;
                end
                s_tvalid <= take;
            end
        end
    end

    // result monitor and receiver backpressure
    always @(posedge aclk) begin : watch_proc
        tick_result_t want;
        tick_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.running_slot = m_tdata[2:0];
                got.job_finished = m_tdata[3];
                got.job_index = m_tdata[19:4];
                got.context_switch = m_tdata[20];
                got.idle_tick = m_tuser;
                if (tick_expect.size() == 0) begin
                    log_fail($sformatf("unexpected result beat slot=%0d idle=%0b",
                                       got.running_slot, got.idle_tick));
                end else begin
                    want = tick_expect.pop_front();
                    if (got.running_slot !== want.running_slot
                            || got.idle_tick !== want.idle_tick
                            || got.job_finished !== want.job_finished
                            || got.job_index !== want.job_index
                            || got.context_switch !== want.context_switch)
                        log_fail($sformatf({"tick mismatch exp slot=%0d idle=%0b done=%0b",
                                            " job=%0d sw=%0b got slot=%0d idle=%0b",
                                            " done=%0b job=%0d sw=%0b"},
                                           want.running_slot, want.idle_tick,
                                           want.job_finished, want.job_index,
                                           want.context_switch, got.running_slot,
                                           got.idle_tick, got.job_finished,
                                           got.job_index, got.context_switch));
                end
            end
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_item(input logic op, input int slot, input int ex, input int per);
        sched_item_t it;
        it.op = op;
        it.slot = SLOT_W'(slot);
        it.exec_t = FIELD_W'(ex);
        it.period = FIELD_W'(per);
        it.drain = drain_next || $urandom_range(0, 59) == 0;
        drain_next = 1'b0;
        pending.push_back(it);
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) queue_item(OP_TICK, 0, 0, 0);
    endtask

    // mostly small task sets followed by tick runs, with some wide-range defines
    task automatic queue_random(input int count);
        int queued;
        int burst;
        queued = 0;
        drain_next = 1'b1;
        while (queued < count) begin
            if ($urandom_range(0, 9) < 8) begin
                burst = $urandom_range(1, 3);
                repeat (burst)
                    queue_item(OP_DEFINE, $urandom_range(0, 7), $urandom_range(1, 4),
                               $urandom_range(1, 12));
                queued += burst;
            end
            if ($urandom_range(0, 9) == 0) begin
                queue_item(OP_DEFINE, $urandom_range(0, 7), $urandom_range(0, 4095),
                           $urandom_range(0, 4095));
                queued++;
            end
            // take a slot out now and then
            if ($urandom_range(0, 14) == 0) begin
                queue_item(OP_DEFINE, $urandom_range(0, 7), 0, $urandom_range(0, 4095));
                queued++;
            end
            burst = $urandom_range(3, 20);
            queue_ticks(burst);
            queued += burst;
        end
    endtask

    // all beats sent, all results back, then let the pipeline settle
    task automatic wait_drained();
        while (pending.size() != 0 || s_tvalid || tick_expect.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_policy(input logic val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        policy = val;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty schedule, extremes, zero period, ties, disable, overrun
        queue_ticks(1);
        queue_item(OP_DEFINE, 0, 4095, 4095);
        queue_item(OP_DEFINE, 7, 1, 0);
        queue_item(OP_DEFINE, 3, 2, 5);
        queue_item(OP_DEFINE, 5, 3, 4);
        queue_item(OP_DEFINE, 6, 3, 4);
        queue_ticks(6);
        queue_item(OP_DEFINE, 7, 0, 9);
        queue_item(OP_DEFINE, 2, 5, 2);
        queue_ticks(6);
        queue_item(OP_DEFINE, 0, 0, 4095);
        queue_ticks(3);
        wait_drained();

        // sender idles 29 percent, receiver stalls 63 percent
        write_policy(POLICY_RMS);
        queue_random(500);
        wait_drained();

        // the other way round
        send_idle_pct = 63;
        recv_stall_pct = 29;
        write_policy(POLICY_EDF);
        queue_random(500);
        wait_drained();

        // full rate on both sides
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_policy(POLICY_RMS);
        queue_random(260);
        wait_drained();
        write_policy(POLICY_EDF);
        queue_random(265);
        wait_drained();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
